FILE: hdl/k_way_sorted_merge_top_assert.svh
// ----------------------------------------------------------------------------
// k-way sorted merge assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_MERGE_TOP_ASSERT_SVH
`define K_WAY_SORTED_MERGE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// plain condition that holds at every edge
`define KWM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("kwm check failed");

// implication in the same cycle
`define KWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwm check failed");

// implication into the next cycle
`define KWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwm check failed");

`else

`define KWM_ASSERT_ALWAYS(lbl, cond)
`define KWM_ASSERT_IMP(lbl, ante, cons)
`define KWM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// shared constants, word types and codes of the k-way sorted merge
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int LANES      = 4;
  localparam int LANE_DEPTH = 16;
  localparam int RESULT_CAP = 64;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 3;

  localparam int IDX_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W   = $clog2(LANES + 1);
  localparam int PTR_W   = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(LANE_DEPTH + 1);
  localparam int STORE_D = LANES * LANE_DEPTH;
  localparam int ADDR_W  = $clog2(STORE_D);
  localparam int RES_W   = $clog2(RESULT_CAP + 1);

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_NEW    = 2'd2
  } kwm_cmd_e;

  typedef enum logic [1:0] {
    KIND_ELEM   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_FULL   = 2'd2,
    KIND_UNUSED = 2'd3
  } kwm_kind_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [1:0]               lane;
    logic signed [DATA_W-1:0] value;
  } kwm_in_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               source_lane;
    logic                     last;
  } kwm_out_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic take;
  } kwm_min_ctl_t;

  // running minimum of one scan
  typedef struct packed {
    logic                     any;
    logic [IDX_W-1:0]         best_lane;
    logic signed [DATA_W-1:0] best_value;
  } kwm_min_sts_t;

endpackage

FILE: hdl/k_way_sorted_merge_top.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top
// merges up to four ascending lane streams into one ascending word stream
// ----------------------------------------------------------------------------
// channel | direction | handshake           | word
// --------+-----------+---------------------+------------------------------
// in      | input     | in_valid / in_stall | cmd, lane, value
// out     | output    | out_valid/out_stall | kind, out_value, source_lane, last
// cfg     | input     | cfg_we              | lanes_in_use
//
// one word at a time: accept, then execute, then per emitted element a scan
//   of n lanes that visits the read state for every lane and adds a compare
//   state for every held lane (ram read then compare), then an end-of-scan
//   read state and a decide state
// the lane store ram and its single read port set the scan length
// reset is synchronous; pointers, counts and finished flags clear at once,
//   the store itself holds no reset value and needs no clearing pass
// out_stall holds the result register; the sequencer waits only when it has
//   a new result and the register is still occupied
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "k_way_sorted_merge_top_assert.svh"

module k_way_sorted_merge_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kwm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kwm_pkg::kwm_in_t              in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kwm_pkg::kwm_out_t             out_word
);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RD     = 5'b00100,
    S_CMP    = 5'b01000,
    S_DECIDE = 5'b10000
  } kwm_state_t;

  kwm_state_t state_r, state_nxt;

  logic [kwm_pkg::CFG_W-1:0] lanes_cfg_r, lanes_cfg_nxt;

  // latched input word
  logic [1:0]                        cmd_r;
  logic [1:0]                        lane_r;
  logic signed [kwm_pkg::DATA_W-1:0] value_r;

  // per-lane fifo bookkeeping
  logic [kwm_pkg::PTR_W-1:0]  rp_r    [kwm_pkg::LANES];
  logic [kwm_pkg::PTR_W-1:0]  rp_nxt  [kwm_pkg::LANES];
  logic [kwm_pkg::FILL_W-1:0] fill_r  [kwm_pkg::LANES];
  logic [kwm_pkg::FILL_W-1:0] fill_nxt[kwm_pkg::LANES];
  logic [kwm_pkg::LANES-1:0]  fin_r, fin_nxt;

  // scan and step bookkeeping
  logic [kwm_pkg::CNT_W-1:0] scan_r, scan_nxt;
  logic                      ready_r, ready_nxt;
  logic [kwm_pkg::RES_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                      newly_r, newly_nxt;
  logic                      emitted_r, emitted_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  kwm_pkg::kwm_out_t out_word_r, out_word_nxt;

  // store ram
  logic                       ram_we;
  logic [kwm_pkg::ADDR_W-1:0] ram_waddr;
  logic [kwm_pkg::ADDR_W-1:0] ram_raddr;
  logic [kwm_pkg::DATA_W-1:0] ram_rdata;

  // compare unit
  kwm_pkg::kwm_min_ctl_t min_ctl;
  kwm_pkg::kwm_min_sts_t min_sts;

  logic [kwm_pkg::CNT_W-1:0]   n_act;
  logic [kwm_pkg::IDX_W-1:0]   lane_idx;
  logic [kwm_pkg::IDX_W-1:0]   scan_idx;
  logic                        lane_ok;
  logic                        lane_full;
  logic [kwm_pkg::PTR_W:0]     wsum;
  logic [kwm_pkg::PTR_W-1:0]   wpos;
  logic                        slot_free;
  logic                        all_done_now;
  logic                        all_done_after;
  logic                        in_acc;

  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign lane_idx  = kwm_pkg::IDX_W'(lane_r);
  assign scan_idx  = kwm_pkg::IDX_W'(scan_r);

  // lanes taking part: zero acts as one, too many clamps to the lane count
  always_comb begin
    if (lanes_cfg_r == '0) begin
      n_act = kwm_pkg::CNT_W'(1);
    end else if (int'(lanes_cfg_r) > kwm_pkg::LANES) begin
      n_act = kwm_pkg::CNT_W'(kwm_pkg::LANES);
    end else begin
      n_act = kwm_pkg::CNT_W'(lanes_cfg_r);
    end
  end

  assign lane_ok   = (int'(lane_r) < int'(n_act)) && !fin_r[lane_idx];
  assign lane_full = (int'(fill_r[lane_idx]) >= kwm_pkg::LANE_DEPTH);

  // tail position of the pushed lane, wraps once at most
  assign wsum = (kwm_pkg::PTR_W + 1)'(rp_r[lane_idx]) +
                (kwm_pkg::PTR_W + 1)'(fill_r[lane_idx]);
  assign wpos = (int'(wsum) >= kwm_pkg::LANE_DEPTH)
              ? kwm_pkg::PTR_W'(wsum - (kwm_pkg::PTR_W + 1)'(kwm_pkg::LANE_DEPTH))
              : kwm_pkg::PTR_W'(wsum);

  assign ram_waddr = kwm_pkg::ADDR_W'(lane_idx) * kwm_pkg::ADDR_W'(kwm_pkg::LANE_DEPTH) +
                     kwm_pkg::ADDR_W'(wpos);
  assign ram_raddr = kwm_pkg::ADDR_W'(scan_idx) * kwm_pkg::ADDR_W'(kwm_pkg::LANE_DEPTH) +
                     kwm_pkg::ADDR_W'(rp_r[scan_idx]);

  // merge end checks, now and after taking the current best head
  always_comb begin
    all_done_now   = 1'b1;
    all_done_after = 1'b1;
    for (int i = 0; i < kwm_pkg::LANES; i++) begin
      if (i < int'(n_act)) begin
        if (!fin_r[i] || fill_r[i] != '0) begin
          all_done_now = 1'b0;
        end
        if (!fin_r[i]) begin
          all_done_after = 1'b0;
        end else if (i == int'(min_sts.best_lane)) begin
          if (int'(fill_r[i]) != 1) begin
            all_done_after = 1'b0;
          end
        end else if (fill_r[i] != '0) begin
          all_done_after = 1'b0;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    lanes_cfg_nxt = cfg_we ? cfg_wdata : lanes_cfg_r;
    rp_nxt        = rp_r;
    fill_nxt      = fill_r;
    fin_nxt       = fin_r;
    scan_nxt      = scan_r;
    ready_nxt     = ready_r;
    res_cnt_nxt   = res_cnt_r;
    newly_nxt     = newly_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    min_ctl       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd_r)
          kwm_pkg::CMD_NEW: begin
            for (int i = 0; i < kwm_pkg::LANES; i++) begin
              rp_nxt[i]   = '0;
              fill_nxt[i] = '0;
            end
            fin_nxt   = '0;
            state_nxt = S_IDLE;
          end
          kwm_pkg::CMD_PUSH: begin
            if (!lane_ok || lane_full) begin
              // drop report goes out before any emission of this step
              if (slot_free) begin
                out_valid_nxt            = 1'b1;
                out_word_nxt.kind        = lane_ok ? kwm_pkg::KIND_FULL
                                                   : kwm_pkg::KIND_UNUSED;
                out_word_nxt.out_value   = '0;
                out_word_nxt.source_lane = lane_r;
                out_word_nxt.last        = 1'b0;
                res_cnt_nxt              = kwm_pkg::RES_W'(1);
                newly_nxt                = 1'b0;
                emitted_nxt              = 1'b0;
                scan_nxt                 = '0;
                ready_nxt                = 1'b1;
                min_ctl.clear            = 1'b1;
                state_nxt                = S_RD;
              end
            end else begin
              ram_we             = 1'b1;
              fill_nxt[lane_idx] = fill_r[lane_idx] + kwm_pkg::FILL_W'(1);
              res_cnt_nxt        = '0;
              newly_nxt          = 1'b0;
              emitted_nxt        = 1'b0;
              scan_nxt           = '0;
              ready_nxt          = 1'b1;
              min_ctl.clear      = 1'b1;
              state_nxt          = S_RD;
            end
          end
          kwm_pkg::CMD_FINISH: begin
            newly_nxt = lane_ok;
            if (lane_ok) begin
              fin_nxt[lane_idx] = 1'b1;
            end
            res_cnt_nxt   = '0;
            emitted_nxt   = 1'b0;
            scan_nxt      = '0;
            ready_nxt     = 1'b1;
            min_ctl.clear = 1'b1;
            state_nxt     = S_RD;
          end
          default: begin
            // unknown command does nothing
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_RD: begin
        if (scan_r == n_act) begin
          state_nxt = S_DECIDE;
        end else if (fill_r[scan_idx] == '0) begin
          // an open empty lane blocks emission
          if (!fin_r[scan_idx]) begin
            ready_nxt = 1'b0;
          end
          scan_nxt = scan_r + kwm_pkg::CNT_W'(1);
        end else begin
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        // head word of scan lane is on the ram output now
        min_ctl.take = 1'b1;
        scan_nxt     = scan_r + kwm_pkg::CNT_W'(1);
        state_nxt    = S_RD;
      end

      S_DECIDE: begin
        if (int'(res_cnt_r) >= kwm_pkg::RESULT_CAP) begin
          state_nxt = S_IDLE;
        end else if (ready_r && min_sts.any) begin
          if (slot_free) begin
            out_valid_nxt            = 1'b1;
            out_word_nxt.kind        = kwm_pkg::KIND_ELEM;
            out_word_nxt.out_value   = min_sts.best_value;
            out_word_nxt.source_lane = 2'(min_sts.best_lane);
            out_word_nxt.last        = all_done_after;
            if (int'(rp_r[min_sts.best_lane]) == kwm_pkg::LANE_DEPTH - 1) begin
              rp_nxt[min_sts.best_lane] = '0;
            end else begin
              rp_nxt[min_sts.best_lane] = rp_r[min_sts.best_lane] + kwm_pkg::PTR_W'(1);
            end
            fill_nxt[min_sts.best_lane] = fill_r[min_sts.best_lane] - kwm_pkg::FILL_W'(1);
            res_cnt_nxt   = res_cnt_r + kwm_pkg::RES_W'(1);
            emitted_nxt   = 1'b1;
            scan_nxt      = '0;
            ready_nxt     = 1'b1;
            min_ctl.clear = 1'b1;
            state_nxt     = S_RD;
          end
        end else if (newly_r && !emitted_r && all_done_now) begin
          // merge closed with nothing left: one finished notice
          if (slot_free) begin
            out_valid_nxt            = 1'b1;
            out_word_nxt.kind        = kwm_pkg::KIND_DONE;
            out_word_nxt.out_value   = '0;
            out_word_nxt.source_lane = '0;
            out_word_nxt.last        = 1'b1;
            res_cnt_nxt              = res_cnt_r + kwm_pkg::RES_W'(1);
            state_nxt                = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lanes_cfg_r <= kwm_pkg::CFG_W'(kwm_pkg::LANES);
      rp_r        <= '{default: '0};
      fill_r      <= '{default: '0};
      fin_r       <= '0;
      scan_r      <= '0;
      ready_r     <= 1'b0;
      res_cnt_r   <= '0;
      newly_r     <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lanes_cfg_r <= lanes_cfg_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      fin_r       <= fin_nxt;
      scan_r      <= scan_nxt;
      ready_r     <= ready_nxt;
      res_cnt_r   <= res_cnt_nxt;
      newly_r     <= newly_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_word.cmd;
      lane_r  <= in_word.lane;
      value_r <= in_word.value;
    end
    out_word_r <= out_word_nxt;
  end

  kwm_ram #(
    .WIDTH (kwm_pkg::DATA_W),
    .DEPTH (kwm_pkg::STORE_D)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kwm_min_unit u_min (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (min_ctl),
    .cand_lane  (scan_idx),
    .cand_value (ram_rdata),
    .sts        (min_sts)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // an accepted word goes straight to execution
  `KWM_ASSERT_NXT(a_acc_exec, in_acc, state_r == S_EXEC)
  // a compare only ever runs on a lane that holds a head
  `KWM_ASSERT_IMP(a_cmp_held, state_r == S_CMP, fill_r[scan_idx] != '0)
  // results of one step never pass the cap
  `KWM_ASSERT_ALWAYS(a_res_cap, int'(res_cnt_r) <= kwm_pkg::RESULT_CAP)

endmodule

FILE: hdl/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/kwm_min_unit.sv
// ----------------------------------------------------------------------------
// kwm_min_unit
// shared signed compare, keeps the smallest lane head of one scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwm_min_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kwm_pkg::kwm_min_ctl_t            ctl,
  input  logic [kwm_pkg::IDX_W-1:0]        cand_lane,
  input  logic signed [kwm_pkg::DATA_W-1:0] cand_value,
  output kwm_pkg::kwm_min_sts_t            sts
);

  logic                              any_r;
  logic                              any_nxt;
  logic [kwm_pkg::IDX_W-1:0]         best_lane_r;
  logic signed [kwm_pkg::DATA_W-1:0] best_value_r;
  logic                              win;

  // strict less-than: on a tie the earlier (lower) lane stays
  assign win = ctl.take && (!any_r || (cand_value < best_value_r));

  always_comb begin
    any_nxt = any_r;
    if (ctl.clear) begin
      any_nxt = 1'b0;
    end else if (win) begin
      any_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else begin
      any_r <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win) begin
      best_lane_r  <= cand_lane;
      best_value_r <= cand_value;
    end
  end

  assign sts.any        = any_r;
  assign sts.best_lane  = best_lane_r;
  assign sts.best_value = best_value_r;

endmodule

FILE: sim/k_way_sorted_merge_top_test.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top_test
// drives lane words into the merge, predicts every merged, notice and drop
// word from its own lane model, and checks the output stream in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module k_way_sorted_merge_top_test;

  import kwm_pkg::*;

  // cmd code with no meaning in the block, must be ignored
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam int IDLE_PCT      = 8;
  localparam int SETTLE_CYCLES = 48;      // longest scan of four lanes plus margin
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 250;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  kwm_in_t              in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  kwm_out_t             out_word;

  // lane model: circular store per lane, head pointer, held count, finished flag
  logic signed [DATA_W-1:0] lane_data [LANES][LANE_DEPTH];
  int                       head_ptr  [LANES];
  int                       held      [LANES];
  bit                       closed    [LANES];
  logic [CFG_W-1:0]         lanes_reg;

  kwm_out_t merged_q [$];   // words still owed by the block, oldest first

  int  errors      = 0;
  int  cycle_count = 0;
  int  items_sent  = 0;     // pushes and finishes only, ignored words not counted
  int  hold_left   = 0;     // receiver hold-off, counted down by the stall process
  bit  quiet       = 1'b0;  // no idling on either side while set

  k_way_sorted_merge_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // lane model
  // ---------------------------------------------------------------------------

  // out-of-range lane counts clamp: 0 acts as one lane, above LANES as LANES
  function automatic int active_lanes();
    if (lanes_reg == 0) return 1;
    if (int'(lanes_reg) > LANES) return LANES;
    return int'(lanes_reg);
  endfunction

  function automatic void clear_lanes();
    for (int i = 0; i < LANES; i++) begin
      head_ptr[i] = 0;
      held[i]     = 0;
      closed[i]   = 1'b0;
    end
  endfunction

  // every lane in use finished and drained
  function automatic bit merge_done(int n);
    for (int i = 0; i < n; i++) begin
      if (!closed[i] || held[i] != 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void owe_word(kwm_kind_e k, logic signed [DATA_W-1:0] v, int src,
                                   bit last);
    kwm_out_t r;
    r.kind        = k;
    r.out_value   = v;
    r.source_lane = 2'(src);
    r.last        = last;
    merged_q.push_back(r);
  endfunction

  // applies one accepted word to the lane model and queues what it causes
  function automatic void predict_merge(kwm_in_t w);
    int                       n;
    int                       count;
    int                       emitted;
    int                       best;
    int                       pos;
    bit                       newly;
    bit                       ready;
    bit                       found;
    logic signed [DATA_W-1:0] best_val;
    n       = active_lanes();
    count   = 0;
    emitted = 0;
    newly   = 1'b0;
    best    = 0;
    best_val = '0;
    case (w.cmd)
      CMD_NEW: begin
        clear_lanes();
        return;
      end
      CMD_PUSH: begin
        // drops come out ahead of any merged words of the same step
        if (int'(w.lane) >= n || closed[w.lane]) begin
          owe_word(KIND_UNUSED, '0, int'(w.lane), 1'b0);
          count++;
        end else if (held[w.lane] >= LANE_DEPTH) begin
          owe_word(KIND_FULL, '0, int'(w.lane), 1'b0);
          count++;
        end else begin
          pos = (head_ptr[w.lane] + held[w.lane]) % LANE_DEPTH;
          lane_data[w.lane][pos] = w.value;
          held[w.lane]++;
        end
      end
      CMD_FINISH: begin
        // finishing an unused or already finished lane does nothing
        if (int'(w.lane) < n && !closed[w.lane]) begin
          closed[w.lane] = 1'b1;
          newly          = 1'b1;
        end
      end
      default: return;
    endcase

    // emit the smallest head while every open lane holds something;
    // strict compare keeps the lower lane on a tie
    while (count < RESULT_CAP) begin
      ready = 1'b1;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (held[i] == 0) begin
          if (!closed[i]) ready = 1'b0;
        end else if (!found || lane_data[i][head_ptr[i]] < best_val) begin
          found    = 1'b1;
          best     = i;
          best_val = lane_data[i][head_ptr[i]];
        end
      end
      if (!ready || !found) break;
      head_ptr[best] = (head_ptr[best] + 1) % LANE_DEPTH;
      held[best]--;
      owe_word(KIND_ELEM, best_val, best, merge_done(n));
      count++;
      emitted++;
    end

    // merge closed with nothing left to hand out: one notice
    if (newly && emitted == 0 && count < RESULT_CAP && merge_done(n))
      owe_word(KIND_DONE, '0, 0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side: random stall, long hold-off on request, in-order check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    kwm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (merged_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d value %0d lane %0d",
                                  out_word.kind, out_word.out_value,
                                  out_word.source_lane));
      end else begin
        want = merged_q.pop_front();
        if (out_word.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_word.kind, want.kind));
        if (out_word.out_value !== want.out_value)
          report_mismatch($sformatf("value %0d, want %0d", out_word.out_value,
                                    want.out_value));
        if (out_word.source_lane !== want.source_lane)
          report_mismatch($sformatf("lane %0d, want %0d", out_word.source_lane,
                                    want.source_lane));
        if (out_word.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_word.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  function automatic kwm_in_t word_of(logic [1:0] cmd, int lane, int value);
    kwm_in_t w;
    w.cmd   = cmd;
    w.lane  = 2'(lane);
    w.value = value;
    return w;
  endfunction

  // valid stays high across back-to-back words; it only drops for a gap
  task automatic send_word(kwm_in_t w);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_merge(w);
    if (w.cmd == CMD_PUSH || w.cmd == CMD_FINISH) items_sent++;
  endtask

  // sender goes idle until the block has handed out everything owed
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (merged_q.size() != 0) @(posedge clk);
  endtask

  // register write only with the block idle; the settle covers words that
  // owe nothing but may still be in the scan
  task automatic write_lanes(logic [CFG_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lanes_reg  = v;
  endtask

  // one merge: ascending random streams per lane, interleaved at random,
  // each lane finished once its stream runs out; a few noise words mixed in
  task automatic run_merge(int max_len);
    int n;
    int len;
    int ln;
    int open_lanes;
    bit narrow;
    int vals [LANES][$];
    bit fin  [LANES];
    n      = active_lanes();
    narrow = ($urandom_range(0, 3) == 0);   // narrow range gives many ties
    send_word(word_of(CMD_NEW, $urandom_range(0, 3), $urandom));
    for (int i = 0; i < LANES; i++) begin
      vals[i].delete();
      fin[i] = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      len = $urandom_range(0, max_len);
      for (int k = 0; k < len; k++)
        vals[i].push_back(narrow ? int'($urandom_range(0, 6)) - 3 : int'($urandom));
      vals[i].sort();
    end
    open_lanes = n;
    while (open_lanes > 0) begin
      ln = $urandom_range(0, n - 1);
      if (!fin[ln]) begin
        if ($urandom_range(0, 99) < 6) begin
          send_word(word_of(2'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom));
        end else if (vals[ln].size() > 0) begin
          send_word(word_of(CMD_PUSH, ln, vals[ln].pop_front()));
        end else begin
          send_word(word_of(CMD_FINISH, ln, $urandom));
          fin[ln] = 1'b1;
          open_lanes--;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // lane count 0 acts as one lane; empty merge, repeated and unused finishes,
  // pushes to finished and unused lanes, unknown command
  task automatic test_empty_merge();
    write_lanes(3'd0);
    send_word(word_of(CMD_NEW, 0, 0));
    send_word(word_of(CMD_FINISH, 0, 0));
    send_word(word_of(CMD_FINISH, 0, 0));
    send_word(word_of(CMD_FINISH, 1, 0));
    send_word(word_of(CMD_PUSH, 0, 32'h7fff_ffff));
    send_word(word_of(CMD_PUSH, 1, 32'h8000_0000));
    send_word(word_of(CMD_UNKNOWN, 3, 32'hffff_ffff));
  endtask

  // lane 0 filled to the brim while lane 1 stays empty, one push past full,
  // then both finished to drain it and close the merge
  task automatic test_full_lane();
    write_lanes(3'd2);
    send_word(word_of(CMD_NEW, 0, 0));
    for (int i = 0; i <= LANE_DEPTH; i++)
      send_word(word_of(CMD_PUSH, 0, (i == 0) ? 32'h8000_0000 : i * 1000));
    send_word(word_of(CMD_FINISH, 1, 0));
    send_word(word_of(CMD_FINISH, 0, 0));
  endtask

  // lane count above LANES acts as all lanes; extreme values with ties, the
  // lower lane must win, and the final element carries the last flag
  task automatic test_ties_and_last();
    write_lanes(3'd7);
    send_word(word_of(CMD_NEW, 0, 0));
    send_word(word_of(CMD_PUSH, 0, 32'h7fff_ffff));
    send_word(word_of(CMD_PUSH, 1, 32'h8000_0000));
    send_word(word_of(CMD_PUSH, 2, 32'h7fff_ffff));
    send_word(word_of(CMD_PUSH, 3, 32'h8000_0000));
    send_word(word_of(CMD_FINISH, 1, 0));
    send_word(word_of(CMD_FINISH, 3, 0));
    send_word(word_of(CMD_FINISH, 2, 0));
    send_word(word_of(CMD_FINISH, 0, 0));
  endtask

  // random merges under every lane count, register rewritten before each batch of one to three merges
  task automatic test_random_merges(int target);
    while (items_sent < target) begin
      write_lanes(3'($urandom_range(0, 7)));
      repeat ($urandom_range(1, 3))
        run_merge(($urandom_range(0, 9) == 0) ? LANE_DEPTH + 2 : $urandom_range(1, 6));
    end
  endtask

  // long stretch with no idling on either side
  task automatic test_back_to_back(int target);
    write_lanes(3'd4);
    quiet = 1'b1;
    while (items_sent < target) run_merge($urandom_range(2, 8));
    wait_drained();
    quiet = 1'b0;
  endtask

  // receiver holds off long enough for the block to fill and stall its input,
  // then the sender waits for everything owed before going on
  task automatic test_output_hold();
    write_lanes(3'd4);
    hold_left = HOLD_CYCLES;
    run_merge(8);
    run_merge(4);
    wait_drained();
    run_merge(4);
  endtask

  initial begin
    int base;
    lanes_reg = 3'd4;
    clear_lanes();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_merge();
    test_full_lane();
    test_ties_and_last();
    base = items_sent;
    test_random_merges(base + RANDOM_ITEMS * 6 / 10);
    test_back_to_back(base + RANDOM_ITEMS * 8 / 10);
    test_output_hold();
    test_random_merges(base + RANDOM_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/kwm_pkg.sv
hdl/kwm_ram.sv
hdl/kwm_min_unit.sv
hdl/k_way_sorted_merge_top.sv
sim/k_way_sorted_merge_top_test.sv
